FILE: rtl/sevseg_pkg.sv
// Shared constants, codes and the segment table for the seven-segment frame generator.
`timescale 1ns / 1ps

package sevseg_pkg;

    typedef enum logic {
        ACTION_SHOW = 1'b0,
        ACTION_CTRL = 1'b1
    } action_t;

    localparam logic [7:0] CTRL_ADDR     = 8'h48;
    localparam logic [7:0] ADDR_THOUSAND = 8'h6C;
    localparam logic [7:0] ADDR_HUNDRED  = 8'h6A;
    localparam logic [7:0] ADDR_TEN      = 8'h68;
    localparam logic [7:0] ADDR_UNIT     = 8'h6E;

    localparam logic [3:0] CTRL_LOW_NIBBLE = 4'h5;
    localparam logic [2:0] BRIGHTNESS_RESET = 3'd1;

    localparam int unsigned RADIX        = 10;
    localparam int unsigned FRAME_MODULO = 10000;

    // Reciprocals for exact division of values below the frame modulo.
    localparam logic [26:0] RECIP_1000 = 27'd8389;
    localparam int unsigned SHIFT_1000 = 23;
    localparam logic [26:0] RECIP_100  = 27'd10486;
    localparam int unsigned SHIFT_100  = 20;
    localparam logic [26:0] RECIP_10   = 27'd13108;
    localparam int unsigned SHIFT_10   = 17;

    typedef logic [3:0] digit_t;
    typedef logic [7:0] byte_t;

    function automatic byte_t seg_of(digit_t d);
        byte_t s;
        begin
            unique case (d)
                4'd0:    s = 8'hF5;
                4'd1:    s = 8'h84;
                4'd2:    s = 8'hB3;
                4'd3:    s = 8'h97;
                4'd4:    s = 8'hC6;
                4'd5:    s = 8'h57;
                4'd6:    s = 8'h77;
                4'd7:    s = 8'h85;
                4'd8:    s = 8'hF7;
                4'd9:    s = 8'hD7;
                default: s = 8'h00;
            endcase
            return s;
        end
    endfunction

    function automatic byte_t digit_addr(logic [1:0] pos);
        byte_t a;
        begin
            unique case (pos)
                2'd0:    a = ADDR_THOUSAND;
                2'd1:    a = ADDR_HUNDRED;
                2'd2:    a = ADDR_TEN;
                default: a = ADDR_UNIT;
            endcase
            return a;
        end
    endfunction

endpackage

FILE: rtl/seven_segment_frame_generator.sv
// Top level: request register, digit split and byte serializer for a four-digit display.
`timescale 1ns / 1ps

// A show request (action 0) yields eight beats: address and segment byte for the
// thousands, hundreds, tens and units digit of number modulo 10000. A control request
// (action 1) yields two beats: 0x48 and brightness*16+5. The serializer sends one byte
// per cycle while out_ready is high. An accepted request is held in the request register
// and then loaded into the frame registers, from which its first beat is offered. A new
// request is taken while the previous frame is still draining, and a next frame already
// held in the request register follows its predecessor's last beat with no gap.
// Brightness resets to 1.
module seven_segment_frame_generator (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 action,
    input  logic [15:0]          number,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           bus_byte,
    output logic                 start_before,
    output logic                 stop_after,
    output logic                 last,
    input  logic                 brightness_we,
    input  logic [2:0]           brightness_wdata
);

    import sevseg_pkg::*;

    logic [2:0]      brightness_val_reg;

    logic            req_valid_reg, req_valid_next;
    action_t         req_action_reg;
    logic [15:0]     req_number_reg;

    logic            frame_valid_reg, frame_valid_next;
    action_t         frame_action_reg;
    byte_t           ctrl_byte_reg;
    byte_t           seg_reg [4];
    logic [2:0]      idx_reg, idx_next;

    logic            in_beat;
    logic            out_beat;
    logic            frame_done;
    logic            frame_load;

    logic [2:0]      wraps;
    logic [15:0]     wrap_sub;
    logic [13:0]     rem;
    logic [26:0]     prod_1000;
    logic [26:0]     prod_100;
    logic [26:0]     prod_10;
    logic [3:0]      q_1000;
    logic [6:0]      q_100;
    logic [9:0]      q_10;
    logic [6:0]      hund_full;
    logic [9:0]      tens_full;
    logic [13:0]     unit_full;
    digit_t          digits [4];

    function automatic logic number_ge(logic [15:0] a, logic [15:0] b);
        return a >= b;
    endfunction

    // brightness register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_val_reg <= BRIGHTNESS_RESET;
        end
        else if (brightness_we)
        begin
            brightness_val_reg <= brightness_wdata;
        end
    end

    assign in_beat    = in_valid && in_ready;
    assign out_beat   = out_valid && out_ready;
    assign frame_done = out_beat && last;
    assign frame_load = req_valid_reg && (!frame_valid_reg || frame_done);
    assign in_ready   = !req_valid_reg || frame_load;

    // number modulo 10000 by parallel compares
    always_comb
    begin
        wraps = 3'(({2'b00, number_ge(req_number_reg, 16'd10000)})
              + ({2'b00, number_ge(req_number_reg, 16'd20000)})
              + ({2'b00, number_ge(req_number_reg, 16'd30000)})
              + ({2'b00, number_ge(req_number_reg, 16'd40000)})
              + ({2'b00, number_ge(req_number_reg, 16'd50000)})
              + ({2'b00, number_ge(req_number_reg, 16'd60000)}));
        wrap_sub = 16'(32'(wraps) * FRAME_MODULO);
        rem      = 14'(req_number_reg - wrap_sub);
    end

    // decimal split by reciprocal multiplication
    always_comb
    begin
        prod_1000 = 27'(rem) * RECIP_1000;
        prod_100  = 27'(rem) * RECIP_100;
        prod_10   = 27'(rem) * RECIP_10;
        q_1000    = prod_1000[SHIFT_1000 +: 4];
        q_100     = prod_100[SHIFT_100 +: 7];
        q_10      = prod_10[SHIFT_10 +: 10];
        hund_full = q_100 - 7'(11'(q_1000) * 11'(RADIX));
        tens_full = q_10 - 10'(14'(q_100) * 14'(RADIX));
        unit_full = rem - 14'(18'(q_10) * 18'(RADIX));
        digits[0] = q_1000;
        digits[1] = hund_full[3:0];
        digits[2] = tens_full[3:0];
        digits[3] = unit_full[3:0];
    end

    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (in_beat)
        begin
            req_valid_next = 1'b1;
        end
        else if (frame_load)
        begin
            req_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        frame_valid_next = frame_valid_reg;
        idx_next         = idx_reg;
        if (frame_load)
        begin
            frame_valid_next = 1'b1;
            idx_next         = '0;
        end
        else if (frame_done)
        begin
            frame_valid_next = 1'b0;
            idx_next         = '0;
        end
        else if (out_beat)
        begin
            idx_next = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg   <= 1'b0;
            frame_valid_reg <= 1'b0;
            idx_reg         <= '0;
        end
        else
        begin
            req_valid_reg   <= req_valid_next;
            frame_valid_reg <= frame_valid_next;
            idx_reg         <= idx_next;
        end
    end

    // hold request and frame payload
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            req_action_reg <= action_t'(action);
            req_number_reg <= number;
        end
        if (frame_load)
        begin
            frame_action_reg <= req_action_reg;
            ctrl_byte_reg    <= {1'b0, brightness_val_reg, CTRL_LOW_NIBBLE};
            for (int i = 0; i < 4; i++)
            begin
                seg_reg[i] <= seg_of(digits[i]);
            end
        end
    end

    // drive current beat
    always_comb
    begin
        out_valid    = frame_valid_reg;
        start_before = !idx_reg[0];
        stop_after   = idx_reg[0];
        if (frame_action_reg == ACTION_CTRL)
        begin
            bus_byte = idx_reg[0] ? ctrl_byte_reg : CTRL_ADDR;
            last     = idx_reg[0];
        end
        else
        begin
            bus_byte = idx_reg[0] ? seg_reg[idx_reg[2:1]] : digit_addr(idx_reg[2:1]);
            last     = (idx_reg == 3'd7);
        end
    end

endmodule
